[rtl/tcw_pkg.sv]
`timescale 1ns / 1ps

package tcw_pkg;

  // Request modes
  localparam logic [1:0] MODE_PUT   = 2'd0;
  localparam logic [1:0] MODE_CLEAR = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;

  // Control characters
  localparam logic [7:0] CHAR_NL  = 8'd10;
  localparam logic [7:0] CHAR_CR  = 8'd13;
  localparam logic [7:0] CHAR_TAB = 8'd9;

  // Blank cell and reset attribute
  localparam logic [7:0] BLANK_CHAR = 8'h20;
  localparam logic [7:0] RESET_ATTR = 8'h07;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  char_code;
    logic [10:0] cell_index;
  } tcw_req_t;

  typedef struct packed {
    logic [4:0]  cursor_row;
    logic [6:0]  cursor_col;
    logic [15:0] read_data;
  } tcw_rsp_t;

endpackage

[rtl/tcw_ram.sv]
`timescale 1ns / 1ps

module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write one entry, register the read data
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

[rtl/text_console_writer.sv]
`timescale 1ns / 1ps
// Each request ends in the done state: a put or an off-screen read goes there directly,
// a read of a screen cell through the read state, a clear through a blank sweep of every
// cell, a put that scrolls through the row copy and a blank sweep of the last row. One
// request at a time, the next taken once the result loads; the scroll copy and the blank
// sweep move one cell per cycle through the screen memory ports. Reset: cursor homes,
// attribute becomes 07, a clearing pass blanks all cells; no request is taken during it.
module text_console_writer
  import tcw_pkg::*;
#(
  parameter int SCREEN_COLS = 80,
  parameter int SCREEN_ROWS = 25
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  tcw_req_t in_req_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output tcw_rsp_t out_rsp_o,
  input  logic     cfg_we_i,
  input  logic [7:0] cfg_wdata_i
);

  localparam int CELL_COUNT = SCREEN_COLS * SCREEN_ROWS;
  localparam int COPY_N     = (SCREEN_ROWS - 1) * SCREEN_COLS;
  localparam int ADDR_W     = $clog2(CELL_COUNT);
  localparam int ROW_W      = $clog2(SCREEN_ROWS);
  localparam int COL_W      = $clog2(SCREEN_COLS);
  localparam int ROW_XW     = ROW_W + 1;
  localparam int COL_XW     = $clog2(SCREEN_COLS + 8);

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_READ,
    S_SCROLL,
    S_BLANK,
    S_DONE
  } state_e;

  state_e              state_q, state_d;
  logic [ROW_W-1:0]    row_q, row_d;
  logic [COL_W-1:0]    col_q, col_d;
  logic [7:0]          attr_q;
  logic [ADDR_W-1:0]   cnt_q, cnt_d;
  logic                pend_q, pend_d;
  logic [15:0]         fill_q, fill_d;
  logic [15:0]         data_q, data_d;
  logic                out_valid_q, out_valid_d;
  tcw_rsp_t            out_q, out_d;

  logic                ram_we, ram_re;
  logic [ADDR_W-1:0]   ram_waddr, ram_raddr;
  logic [15:0]         ram_wdata, ram_rdata;

  logic                in_acc;
  logic [COL_XW-1:0]   col_ext, col_n;
  logic [ROW_XW-1:0]   row_ext, row_n;
  logic                put_write;

  assign in_acc = in_valid_i && !in_stall_o;

  // Next cursor for a put request
  always_comb begin
    col_ext   = COL_XW'(col_q);
    row_ext   = ROW_XW'(row_q);
    col_n     = col_ext;
    row_n     = row_ext;
    put_write = 1'b0;
    case (in_req_i.char_code)
      CHAR_NL: begin
        col_n = '0;
        row_n = row_ext + ROW_XW'(1);
      end
      CHAR_CR: begin
        col_n = '0;
      end
      CHAR_TAB: begin
        col_n = (col_ext + COL_XW'(8)) & ~COL_XW'(7);
      end
      default: begin
        put_write = 1'b1;
        col_n     = col_ext + COL_XW'(1);
      end
    endcase
    if (col_n >= COL_XW'(SCREEN_COLS)) begin
      col_n = '0;
      row_n = row_n + ROW_XW'(1);
    end
  end

  // Sequence requests and drive the memory ports
  always_comb begin
    state_d     = state_q;
    row_d       = row_q;
    col_d       = col_q;
    cnt_d       = cnt_q;
    pend_d      = 1'b0;
    fill_d      = fill_q;
    data_d      = data_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    ram_we      = 1'b0;
    ram_waddr   = cnt_q;
    ram_wdata   = fill_q;
    ram_re      = 1'b0;
    ram_raddr   = ADDR_W'(in_req_i.cell_index);

    case (state_q)
      S_INIT: begin
        ram_we    = 1'b1;
        ram_wdata = {RESET_ATTR, BLANK_CHAR};
        cnt_d     = cnt_q + ADDR_W'(1);
        if (cnt_q == ADDR_W'(CELL_COUNT - 1)) begin
          cnt_d   = '0;
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          data_d  = '0;
          state_d = S_DONE;
          case (in_req_i.mode)
            MODE_PUT: begin
              ram_we    = put_write;
              ram_waddr = ADDR_W'(32'(row_q) * SCREEN_COLS + 32'(col_q));
              ram_wdata = {attr_q, in_req_i.char_code};
              col_d     = COL_W'(col_n);
              if (row_n >= ROW_XW'(SCREEN_ROWS)) begin
                row_d   = ROW_W'(SCREEN_ROWS - 1);
                fill_d  = {attr_q, BLANK_CHAR};
                cnt_d   = '0;
                state_d = S_SCROLL;
              end else begin
                row_d = ROW_W'(row_n);
              end
            end
            MODE_CLEAR: begin
              row_d   = '0;
              col_d   = '0;
              fill_d  = {attr_q, BLANK_CHAR};
              cnt_d   = '0;
              state_d = S_BLANK;
            end
            MODE_READ: begin
              if (32'(in_req_i.cell_index) < CELL_COUNT) begin
                ram_re  = 1'b1;
                state_d = S_READ;
              end
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end
      S_READ: begin
        data_d  = ram_rdata;
        state_d = S_DONE;
      end
      S_SCROLL: begin
        // Read one row ahead, write back the cell fetched last cycle
        ram_we    = pend_q;
        ram_wdata = ram_rdata;
        ram_waddr = cnt_q - ADDR_W'(1);
        if (cnt_q == ADDR_W'(COPY_N)) begin
          state_d = S_BLANK;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = cnt_q + ADDR_W'(SCREEN_COLS);
          pend_d    = 1'b1;
          cnt_d     = cnt_q + ADDR_W'(1);
        end
      end
      S_BLANK: begin
        ram_we = 1'b1;
        cnt_d  = cnt_q + ADDR_W'(1);
        if (cnt_q == ADDR_W'(CELL_COUNT - 1)) begin
          cnt_d   = '0;
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        // Hold until the output register is free
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d          = 1'b1;
          out_d.cursor_row     = 5'(row_q);
          out_d.cursor_col     = 7'(col_q);
          out_d.read_data      = data_q;
          state_d              = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Hold state, cursor and the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      row_q       <= '0;
      col_q       <= '0;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
      attr_q      <= RESET_ATTR;
    end else begin
      state_q     <= state_d;
      row_q       <= row_d;
      col_q       <= col_d;
      cnt_q       <= cnt_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        attr_q <= cfg_wdata_i;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    fill_q <= fill_d;
    data_q <= data_d;
    out_q  <= out_d;
  end

  tcw_ram #(
    .WIDTH(16),
    .DEPTH(CELL_COUNT)
  ) u_screen (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  // Cursor stays on the screen
  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(row_q) < SCREEN_ROWS) && (32'(col_q) < SCREEN_COLS))
    else $error("cursor outside screen");

  // A scroll always leaves the cursor on the last row
  a_scroll_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCROLL) |-> (32'(row_q) == SCREEN_ROWS - 1))
    else $error("scroll with cursor off the last row");

  // Memory writes stay inside the screen
  a_write_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (32'(ram_waddr) < CELL_COUNT))
    else $error("screen write out of range");

  // No result is produced during the reset clearing pass
  a_init_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_INIT) |-> !out_valid_q)
    else $error("result during clearing pass");

  // A result is loaded only on leaving the done state
  a_load_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($rose(out_valid_q)) |-> ($past(state_q) == S_DONE))
    else $error("result loaded outside done state");

endmodule
